/* rtl/geomorph_grid_mesh_generator_defines.svh */
// Assertion macros shared by the grid mesh generator RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef GEOMORPH_GRID_MESH_GENERATOR_DEFINES_SVH
`define GEOMORPH_GRID_MESH_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GGM_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GGM_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ggm_pkg.sv */
// Types, constants and helper functions of the grid mesh generator.
// Used by every module of the block; depends on nothing.
package ggm_pkg;

  localparam int unsigned MAX_GRID_SIDE = 1023;

  localparam int unsigned SIDE_W  = 10;
  localparam int unsigned PIVOT_W = 11;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned IDX_W   = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_FLIP_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_FLIP_Z   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL_SHIFT = 3'd7;

  localparam logic [1:0] MORPH_NONE = 2'b00;
  localparam logic [1:0] MORPH_UP   = 2'b01;
  localparam logic [1:0] MORPH_DOWN = 2'b11;

  typedef struct packed {
    logic [SIDE_W-1:0]  grid_width;
    logic [SIDE_W-1:0]  grid_height;
    logic [PIVOT_W-1:0] pivot_x;
    logic [PIVOT_W-1:0] pivot_z;
    logic               morph_enable;
    logic               morph_flip_x;
    logic               morph_flip_z;
    logic               diagonal_shift;
  } cfg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] column;
    logic [SIDE_W-1:0] row;
  } point_t;

  // Intermediate stage: everything but the final index adds.
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic [1:0]              morph_dx;
    logic [1:0]              morph_dz;
    logic                    out_of_range;
    logic                    has_quad;
    logic                    diag_odd;
    logic [SIDE_W-1:0]       column;
    logic [SIDE_W-1:0]       width;
    logic [IDX_W-1:0]        row_base;
  } mid_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
    logic [1:0]              morph_dx;
    logic [1:0]              morph_dz;
    logic                    has_quad;
    logic [IDX_W-1:0]        tri0_a;
    logic [IDX_W-1:0]        tri0_b;
    logic [IDX_W-1:0]        tri0_c;
    logic [IDX_W-1:0]        tri1_a;
    logic [IDX_W-1:0]        tri1_b;
    logic [IDX_W-1:0]        tri1_c;
    logic                    out_of_range;
  } res_t;

  function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
    if (32'(v) > MAX_GRID_SIDE) begin
      return SIDE_W'(MAX_GRID_SIDE);
    end
    return v;
  endfunction

  // An odd coordinate moves up when bit 1 differs from the flip flag.
  function automatic logic [1:0] morph_code(logic [SIDE_W-1:0] c, logic flip);
    if (!c[0]) begin
      return MORPH_NONE;
    end
    return (c[1] ^ flip) ? MORPH_UP : MORPH_DOWN;
  endfunction

endpackage

/* rtl/ggm_front.sv */
// First compute stage: range checks, positions, morph offsets and row base product.
// Depends on ggm_pkg.
module ggm_front (
  input  ggm_pkg::cfg_t   cfg,
  input  ggm_pkg::point_t pt,
  output ggm_pkg::mid_t   mid
);
  import ggm_pkg::*;

  logic [SIDE_W-1:0]   w;
  logic [SIDE_W-1:0]   h;
  logic                oor;
  logic [SIDE_W:0]     w_plus;
  logic [2*SIDE_W:0]   prod;

  assign w      = clamp_side(cfg.grid_width);
  assign h      = clamp_side(cfg.grid_height);
  assign oor    = (pt.column > w) || (pt.row > h);
  assign w_plus = {1'b0, w} + (SIDE_W+1)'(1);
  assign prod   = pt.row * w_plus;

  always_comb begin
    mid.out_of_range = oor;
    mid.has_quad     = !oor && (pt.column < w) && (pt.row < h);
    mid.diag_odd     = pt.row[0] ^ pt.column[0] ^ cfg.diagonal_shift;
    mid.column       = pt.column;
    mid.width        = w;
    mid.row_base     = prod[IDX_W-1:0];
    mid.pos_x        = '0;
    mid.pos_z        = '0;
    mid.morph_dx     = MORPH_NONE;
    mid.morph_dz     = MORPH_NONE;
    if (!oor) begin
      mid.pos_x = $signed({2'b00, pt.column} - {1'b0, cfg.pivot_x});
      mid.pos_z = $signed({2'b00, pt.row} - {1'b0, cfg.pivot_z});
      if (cfg.morph_enable) begin
        mid.morph_dx = morph_code(pt.column, cfg.morph_flip_x);
        mid.morph_dz = morph_code(pt.row, cfg.morph_flip_z);
      end
    end
  end

endmodule

/* rtl/ggm_back.sv */
// Second compute stage: corner indices of the quad and diagonal selection.
// Depends on ggm_pkg.
module ggm_back (
  input  ggm_pkg::mid_t mid,
  output ggm_pkg::res_t res
);
  import ggm_pkg::*;

  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] up;
  logic [IDX_W-1:0] upr;
  logic [IDX_W-1:0] rt;

  assign k   = mid.row_base + IDX_W'(mid.column);
  assign up  = k + IDX_W'(mid.width) + IDX_W'(1);
  assign upr = k + IDX_W'(mid.width) + IDX_W'(2);
  assign rt  = k + IDX_W'(1);

  always_comb begin
    res.pos_x        = mid.pos_x;
    res.pos_z        = mid.pos_z;
    res.morph_dx     = mid.morph_dx;
    res.morph_dz     = mid.morph_dz;
    res.has_quad     = mid.has_quad;
    res.out_of_range = mid.out_of_range;
    res.tri0_a = '0;
    res.tri0_b = '0;
    res.tri0_c = '0;
    res.tri1_a = '0;
    res.tri1_b = '0;
    res.tri1_c = '0;
    if (mid.has_quad) begin
      res.tri0_a = k;
      res.tri0_b = up;
      if (!mid.diag_odd) begin
        res.tri0_c = upr;
        res.tri1_a = k;
        res.tri1_b = upr;
        res.tri1_c = rt;
      end else begin
        res.tri0_c = rt;
        res.tri1_a = rt;
        res.tri1_b = up;
        res.tri1_c = upr;
      end
    end
  end

endmodule

/* rtl/geomorph_grid_mesh_generator.sv */
// Grid mesh point generator: one vertex and its quad per beat.
// Depends on ggm_pkg, ggm_front, ggm_back and the assertion macro header.
// An accepted input beat reaches the output beat through three registers:
// input register, a stage after the row * (width + 1) product, result register.
// Throughput is one beat per cycle; with the output held, the input stalls once all three hold a beat.
// Synchronous active-high reset empties the pipeline and restores register defaults.
module geomorph_grid_mesh_generator (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [10:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // column[9:0], row[19:10], zero pad
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,   // pos_x, pos_z, morph_dx, morph_dz, tri0_a..c,
                                  // tri1_a..c, zero pad
  output logic [1:0]   m_tuser    // has_quad, out_of_range
);
  import ggm_pkg::*;
  `include "geomorph_grid_mesh_generator_defines.svh"

  cfg_t   cfg;
  point_t in_pt;
  logic   in_valid;
  mid_t   mid_next;
  mid_t   mid;
  logic   mid_valid;
  res_t   res_next;
  res_t   res;
  logic   res_valid;
  logic   adv_out;
  logic   adv_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width     <= SIDE_W'(1);
      cfg.grid_height    <= SIDE_W'(1);
      cfg.pivot_x        <= '0;
      cfg.pivot_z        <= '0;
      cfg.morph_enable   <= 1'b0;
      cfg.morph_flip_x   <= 1'b0;
      cfg.morph_flip_z   <= 1'b0;
      cfg.diagonal_shift <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_GRID_WIDTH:     cfg.grid_width     <= cfg_data[SIDE_W-1:0];
        REG_GRID_HEIGHT:    cfg.grid_height    <= cfg_data[SIDE_W-1:0];
        REG_PIVOT_X:        cfg.pivot_x        <= cfg_data[PIVOT_W-1:0];
        REG_PIVOT_Z:        cfg.pivot_z        <= cfg_data[PIVOT_W-1:0];
        REG_MORPH_ENABLE:   cfg.morph_enable   <= cfg_data[0];
        REG_MORPH_FLIP_X:   cfg.morph_flip_x   <= cfg_data[0];
        REG_MORPH_FLIP_Z:   cfg.morph_flip_z   <= cfg_data[0];
        REG_DIAGONAL_SHIFT: cfg.diagonal_shift <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage moves on when the one after it is empty or moving.
  assign adv_out  = !res_valid || m_tready;
  assign adv_mid  = !mid_valid || adv_out;
  assign s_tready = !in_valid || adv_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv_mid) begin
        mid_valid <= in_valid;
      end
      if (adv_out) begin
        res_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pt.column <= s_tdata[9:0];
      in_pt.row    <= s_tdata[19:10];
    end
    if (adv_mid && in_valid) begin
      mid <= mid_next;
    end
    if (adv_out && mid_valid) begin
      res <= res_next;
    end
  end

  ggm_front u_front (
    .cfg (cfg),
    .pt  (in_pt),
    .mid (mid_next)
  );

  ggm_back u_back (
    .mid (mid),
    .res (res_next)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {4'b0000, res.tri1_c, res.tri1_b, res.tri1_a, res.tri0_c, res.tri0_b,
                     res.tri0_a, res.morph_dz, res.morph_dx, res.pos_z, res.pos_x};
  assign m_tuser  = {res.out_of_range, res.has_quad};

  `GGM_ASSERT_NOW(a_oor_clears_fields, clk, rst, m_tvalid && m_tuser[1],
    !m_tuser[0] && (m_tdata == '0), "out-of-range result carries nonzero fields")
  `GGM_ASSERT_NOW(a_no_quad_no_tris, clk, rst, m_tvalid && !m_tuser[0],
    m_tdata[147:28] == '0, "triangle indices present without a quad")
  `GGM_ASSERT_NOW(a_morph_code_legal, clk, rst, m_tvalid,
    (m_tdata[25:24] != 2'b10) && (m_tdata[27:26] != 2'b10), "illegal morph offset code")
  `GGM_ASSERT_NEXT(a_input_stage_holds, clk, rst, in_valid && !adv_mid,
    in_valid && $stable(in_pt), "stalled input stage lost or changed its point")

endmodule
